[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// shared concurrent assertion macros for the follower core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, held off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/epf_pkg.sv]
// ----------------------------------------------------------------------------
// epf_pkg
// shared widths, constants, types and arithmetic helpers of the follower
// ----------------------------------------------------------------------------
package epf_pkg;

    // coordinate and arithmetic widths
    localparam int COORD_WIDTH = 24;
    localparam int DIFF_W      = COORD_WIDTH + 1;
    localparam int MUL_A_W     = COORD_WIDTH + 2;
    localparam int GAIN_W      = 17;
    localparam int MUL_B_W     = GAIN_W + 1;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int FRAC_BITS   = 16;
    localparam int SUM_W       = PROD_W - FRAC_BITS;

    // configuration port
    localparam int SMOOTH_W   = 16;
    localparam int RESP_W     = 14;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    localparam logic [SMOOTH_W-1:0] SMOOTH_MIN   = SMOOTH_W'(6554);
    localparam logic [SMOOTH_W-1:0] SMOOTH_MAX   = SMOOTH_W'(58982);
    localparam logic [SMOOTH_W-1:0] SMOOTH_RESET = SMOOTH_W'(58982);
    localparam logic [RESP_W-1:0]   RESP_MIN     = RESP_W'(655);
    localparam logic [RESP_W-1:0]   RESP_MAX     = RESP_W'(13107);
    localparam logic [RESP_W-1:0]   RESP_RESET   = RESP_W'(5243);
    localparam logic [GAIN_W-1:0]   ONE_Q16      = GAIN_W'(65536);

    // arrival threshold: 0.1 is 25.6 lsb, squared 655.36
    localparam int STOP_LSB = 26;
    localparam int STOP_SQ  = 655;
    localparam int SML_W    = 6;
    localparam int SQ_W     = 2 * SML_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTH = 1'b0,
        CFG_RESP   = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IDEAL_X,
        ST_BLEND_X,
        ST_VEL_X,
        ST_POS_X,
        ST_IDEAL_Y,
        ST_BLEND_Y,
        ST_VEL_Y,
        ST_POS_Y,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TARGET,
        OP_MUL_IDEAL,
        OP_MUL_BLEND,
        OP_VEL,
        OP_POS,
        OP_CHECK,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic axis_y;
    } t_cmd;

    typedef struct packed {
        logic armed;
        logic out_free;
    } t_status;

    // clamp a widened sum into the signed coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
        input logic signed [SUM_W-1:0] v
    );
        logic ovf;
        ovf = (v[SUM_W-1:COORD_WIDTH-1] != {(SUM_W-COORD_WIDTH+1){v[SUM_W-1]}});
        if (!ovf) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[SUM_W-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    // both components inside the stop circle (squared compare)
    function automatic logic below_stop(
        input logic signed [DIFF_W-1:0] a,
        input logic signed [DIFF_W-1:0] b
    );
        logic signed [DIFF_W-1:0] lim_hi;
        logic signed [DIFF_W-1:0] lim_lo;
        logic signed [SML_W-1:0]  a_s;
        logic signed [SML_W-1:0]  b_s;
        logic signed [SQ_W-1:0]   a_w;
        logic signed [SQ_W-1:0]   b_w;
        logic [SQ_W-1:0]          sq_a;
        logic [SQ_W-1:0]          sq_b;
        logic [SQ_W:0]            sq_sum;
        lim_hi = DIFF_W'(STOP_LSB);
        lim_lo = -lim_hi;
        a_s    = a[SML_W-1:0];
        b_s    = b[SML_W-1:0];
        a_w    = SQ_W'(a_s);
        b_w    = SQ_W'(b_s);
        sq_a   = a_w * a_w;
        sq_b   = b_w * b_w;
        sq_sum = {1'b0, sq_a} + {1'b0, sq_b};
        return (a < lim_hi) && (a > lim_lo) && (b < lim_hi) && (b > lim_lo)
            && (sq_sum <= (SQ_W+1)'(STOP_SQ));
    endfunction

endpackage

[rtl/core/epf_ctrl.sv]
// ----------------------------------------------------------------------------
// epf_ctrl
// sequencer of the follower: accepts beats and steps the shared multiplier
// through both axes, the arrival check and the result hand-off
// ----------------------------------------------------------------------------
module epf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_mode,
    input  epf_pkg::t_status i_status,
    output logic             o_ready,
    output epf_pkg::t_cmd    o_cmd
);

    epf_pkg::t_state r_state;
    epf_pkg::t_state n_state;
    logic            accept;

    assign accept = i_valid && (r_state == epf_pkg::ST_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            epf_pkg::ST_IDLE: begin
                if (accept && i_mode && i_status.armed) begin
                    n_state = epf_pkg::ST_IDEAL_X;
                end
            end
            epf_pkg::ST_IDEAL_X: n_state = epf_pkg::ST_BLEND_X;
            epf_pkg::ST_BLEND_X: n_state = epf_pkg::ST_VEL_X;
            epf_pkg::ST_VEL_X:   n_state = epf_pkg::ST_POS_X;
            epf_pkg::ST_POS_X:   n_state = epf_pkg::ST_IDEAL_Y;
            epf_pkg::ST_IDEAL_Y: n_state = epf_pkg::ST_BLEND_Y;
            epf_pkg::ST_BLEND_Y: n_state = epf_pkg::ST_VEL_Y;
            epf_pkg::ST_VEL_Y:   n_state = epf_pkg::ST_POS_Y;
            epf_pkg::ST_POS_Y:   n_state = epf_pkg::ST_CHECK;
            epf_pkg::ST_CHECK:   n_state = epf_pkg::ST_EMIT;
            epf_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = epf_pkg::ST_IDLE;
                end
            end
            default: n_state = epf_pkg::ST_IDLE;
        endcase
    end

    // command decode
    always_comb begin
        o_ready      = 1'b0;
        o_cmd.op     = epf_pkg::OP_NONE;
        o_cmd.axis_y = 1'b0;
        case (r_state)
            epf_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                if (accept && !i_mode) begin
                    o_cmd.op = epf_pkg::OP_TARGET;
                end
            end
            epf_pkg::ST_IDEAL_X: o_cmd.op = epf_pkg::OP_MUL_IDEAL;
            epf_pkg::ST_BLEND_X: o_cmd.op = epf_pkg::OP_MUL_BLEND;
            epf_pkg::ST_VEL_X:   o_cmd.op = epf_pkg::OP_VEL;
            epf_pkg::ST_POS_X:   o_cmd.op = epf_pkg::OP_POS;
            epf_pkg::ST_IDEAL_Y: begin
                o_cmd.op     = epf_pkg::OP_MUL_IDEAL;
                o_cmd.axis_y = 1'b1;
            end
            epf_pkg::ST_BLEND_Y: begin
                o_cmd.op     = epf_pkg::OP_MUL_BLEND;
                o_cmd.axis_y = 1'b1;
            end
            epf_pkg::ST_VEL_Y: begin
                o_cmd.op     = epf_pkg::OP_VEL;
                o_cmd.axis_y = 1'b1;
            end
            epf_pkg::ST_POS_Y: begin
                o_cmd.op     = epf_pkg::OP_POS;
                o_cmd.axis_y = 1'b1;
            end
            epf_pkg::ST_CHECK: o_cmd.op = epf_pkg::OP_CHECK;
            epf_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.op = epf_pkg::OP_EMIT;
                end
            end
            default: o_cmd.op = epf_pkg::OP_NONE;
        endcase
    end

endmodule

[rtl/core/epf_dp.sv]
// ----------------------------------------------------------------------------
// epf_dp
// follower datapath: gain registers, target/position/velocity state, one
// shared multiplier, arrival check and the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epf_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  epf_pkg::t_cmd                          i_cmd,
    input  logic                                   i_cfg_we,
    input  logic [epf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [epf_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    input  logic signed [epf_pkg::COORD_WIDTH-1:0] i_goal_x,
    input  logic signed [epf_pkg::COORD_WIDTH-1:0] i_goal_y,
    input  logic                                   i_ready,
    output epf_pkg::t_status                       o_status,
    output logic                                   o_valid,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_pos_x,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_pos_y,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_vel_x,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_vel_y,
    output logic                                   o_arrived
);

    logic [epf_pkg::SMOOTH_W-1:0]            r_smooth;
    logic [epf_pkg::RESP_W-1:0]              r_resp;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_tgt_x;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_tgt_y;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_pos_x;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_pos_y;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_vel_x;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_vel_y;
    logic                                    r_armed;
    logic                                    r_hit;
    logic signed [epf_pkg::PROD_W-1:0]       r_prod;
    logic                                    r_out_valid;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_out_pos_x;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_out_pos_y;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_out_vel_x;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  r_out_vel_y;
    logic                                    r_out_arrived;

    logic [epf_pkg::SMOOTH_W-1:0]            smooth_wr;
    logic [epf_pkg::RESP_W-1:0]              resp_wr;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  tgt_sel;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  pos_sel;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  vel_sel;
    logic signed [epf_pkg::DIFF_W-1:0]       diff;
    logic signed [epf_pkg::SUM_W-1:0]        prod_sh;
    logic signed [epf_pkg::DIFF_W-1:0]       ideal;
    logic signed [epf_pkg::MUL_A_W-1:0]      blend_in;
    logic [epf_pkg::GAIN_W-1:0]              gain;
    logic signed [epf_pkg::MUL_A_W-1:0]      mul_a;
    logic signed [epf_pkg::MUL_B_W-1:0]      mul_b;
    logic signed [epf_pkg::PROD_W-1:0]       mul_p;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  vel_new;
    logic signed [epf_pkg::COORD_WIDTH-1:0]  pos_new;
    logic signed [epf_pkg::DIFF_W-1:0]       dist_x;
    logic signed [epf_pkg::DIFF_W-1:0]       dist_y;
    logic                                    hit;
    logic                                    out_free;

    // saturating configuration writes
    always_comb begin
        smooth_wr = i_cfg_data[epf_pkg::SMOOTH_W-1:0];
        if (smooth_wr < epf_pkg::SMOOTH_MIN) begin
            smooth_wr = epf_pkg::SMOOTH_MIN;
        end else if (smooth_wr > epf_pkg::SMOOTH_MAX) begin
            smooth_wr = epf_pkg::SMOOTH_MAX;
        end
        resp_wr = i_cfg_data[epf_pkg::RESP_W-1:0];
        if (resp_wr < epf_pkg::RESP_MIN) begin
            resp_wr = epf_pkg::RESP_MIN;
        end else if (resp_wr > epf_pkg::RESP_MAX) begin
            resp_wr = epf_pkg::RESP_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smooth <= epf_pkg::SMOOTH_RESET;
            r_resp   <= epf_pkg::RESP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                epf_pkg::CFG_SMOOTH: r_smooth <= smooth_wr;
                epf_pkg::CFG_RESP:   r_resp   <= resp_wr;
                default: ;
            endcase
        end
    end

    // axis selection
    assign tgt_sel = i_cmd.axis_y ? r_tgt_y : r_tgt_x;
    assign pos_sel = i_cmd.axis_y ? r_pos_y : r_pos_x;
    assign vel_sel = i_cmd.axis_y ? r_vel_y : r_vel_x;

    // shared multiplier operands: distance * gain, then (ideal - v) * (1 - smooth)
    assign diff     = epf_pkg::DIFF_W'(tgt_sel) - epf_pkg::DIFF_W'(pos_sel);
    assign prod_sh  = r_prod[epf_pkg::PROD_W-1:epf_pkg::FRAC_BITS];
    assign ideal    = prod_sh[epf_pkg::DIFF_W-1:0];
    assign blend_in = epf_pkg::MUL_A_W'(ideal) - epf_pkg::MUL_A_W'(vel_sel);
    assign gain     = (i_cmd.op == epf_pkg::OP_MUL_IDEAL)
                    ? epf_pkg::GAIN_W'(r_resp)
                    : epf_pkg::ONE_Q16 - epf_pkg::GAIN_W'(r_smooth);
    assign mul_a    = (i_cmd.op == epf_pkg::OP_MUL_IDEAL)
                    ? epf_pkg::MUL_A_W'(diff) : blend_in;
    assign mul_b    = $signed({1'b0, gain});
    assign mul_p    = mul_a * mul_b;

    // velocity and position updates
    assign vel_new = epf_pkg::sat_coord(epf_pkg::SUM_W'(vel_sel) + prod_sh);
    assign pos_new = epf_pkg::sat_coord(epf_pkg::SUM_W'(pos_sel)
                                        + epf_pkg::SUM_W'(vel_sel));

    // arrival test on the updated state
    assign dist_x = epf_pkg::DIFF_W'(r_tgt_x) - epf_pkg::DIFF_W'(r_pos_x);
    assign dist_y = epf_pkg::DIFF_W'(r_tgt_y) - epf_pkg::DIFF_W'(r_pos_y);
    assign hit    = epf_pkg::below_stop(epf_pkg::DIFF_W'(r_vel_x),
                                        epf_pkg::DIFF_W'(r_vel_y))
                 && epf_pkg::below_stop(dist_x, dist_y);

    // product register
    always_ff @(posedge i_clk) begin
        if ((i_cmd.op == epf_pkg::OP_MUL_IDEAL) || (i_cmd.op == epf_pkg::OP_MUL_BLEND)) begin
            r_prod <= mul_p;
        end
    end

    // follower state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_x <= '0;
            r_tgt_y <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_vel_x <= '0;
            r_vel_y <= '0;
            r_armed <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            case (i_cmd.op)
                epf_pkg::OP_TARGET: begin
                    r_tgt_x <= i_goal_x;
                    r_tgt_y <= i_goal_y;
                    r_armed <= 1'b1;
                end
                epf_pkg::OP_VEL: begin
                    if (i_cmd.axis_y) begin
                        r_vel_y <= vel_new;
                    end else begin
                        r_vel_x <= vel_new;
                    end
                end
                epf_pkg::OP_POS: begin
                    if (i_cmd.axis_y) begin
                        r_pos_y <= pos_new;
                    end else begin
                        r_pos_x <= pos_new;
                    end
                end
                epf_pkg::OP_CHECK: begin
                    r_hit <= hit;
                    if (hit) begin
                        r_pos_x <= r_tgt_x;
                        r_pos_y <= r_tgt_y;
                        r_vel_x <= '0;
                        r_vel_y <= '0;
                        r_armed <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == epf_pkg::OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == epf_pkg::OP_EMIT) begin
            r_out_pos_x   <= r_pos_x;
            r_out_pos_y   <= r_pos_y;
            r_out_vel_x   <= r_vel_x;
            r_out_vel_y   <= r_vel_y;
            r_out_arrived <= r_hit;
        end
    end

    assign o_status.armed    = r_armed;
    assign o_status.out_free = out_free;
    assign o_valid           = r_out_valid;
    assign o_out_pos_x       = r_out_pos_x;
    assign o_out_pos_y       = r_out_pos_y;
    assign o_out_vel_x       = r_out_vel_x;
    assign o_out_vel_y       = r_out_vel_y;
    assign o_arrived         = r_out_arrived;

    // checks
    `ASSERT_NXT(a_hit_disarms, i_clk, i_rst_n, (i_cmd.op == epf_pkg::OP_CHECK) && hit, !r_armed && r_hit)
    `ASSERT_IMP(a_emit_free, i_clk, i_rst_n, i_cmd.op == epf_pkg::OP_EMIT, !r_out_valid || i_ready)
    `ASSERT_NXT(a_emit_valid, i_clk, i_rst_n, i_cmd.op == epf_pkg::OP_EMIT, r_out_valid)
    `ASSERT_IMP(a_arrive_still, i_clk, i_rst_n, r_out_valid && r_out_arrived, (r_out_vel_x == '0) && (r_out_vel_y == '0))

endmodule

[rtl/core/elastic_position_follower.sv]
// ----------------------------------------------------------------------------
// elastic_position_follower
// 2d spring-damper position follower with saturating fixed-point arithmetic
// ----------------------------------------------------------------------------
// usage:
//   input channel (i_valid/o_ready): a beat with i_mode = 0 loads a new
//   target from i_goal_x/i_goal_y and arms the follower; a beat with
//   i_mode = 1 is a timer tick. Ticks while disarmed are dropped.
//   output channel (o_valid/i_ready): one beat per armed tick with the new
//   position, velocity and o_arrived, set when the point snapped to target.
//   config port: i_cfg_we writes i_cfg_idx (0 smoothness, 1 responsiveness),
//   values clamped to their legal range; write only while idle.
// sequence:
//   a target beat or a dropped tick is handled in the idle state. An armed
//   tick runs 4 steps per axis (ideal and blend products on the one shared
//   multiplier, then velocity and position), one arrival check and one load
//   of the output register; no new beat is accepted until that load.
// reset: position, velocity and target clear, gains return to defaults,
//   the follower is disarmed and the output register empties.
// stall: a held result sits in the output register while a new beat is
//   accepted; the next result waits in its load step until the slot frees.
// ----------------------------------------------------------------------------
module elastic_position_follower (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_mode,
    input  logic signed [epf_pkg::COORD_WIDTH-1:0] i_goal_x,
    input  logic signed [epf_pkg::COORD_WIDTH-1:0] i_goal_y,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_pos_x,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_pos_y,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_vel_x,
    output logic signed [epf_pkg::COORD_WIDTH-1:0] o_out_vel_y,
    output logic                                   o_arrived,
    input  logic                                   i_cfg_we,
    input  logic [epf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [epf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    epf_pkg::t_cmd    cmd;
    epf_pkg::t_status status;

    // sequencer
    epf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (status),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    // arithmetic and state
    epf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_goal_x    (i_goal_x),
        .i_goal_y    (i_goal_y),
        .i_ready     (i_ready),
        .o_status    (status),
        .o_valid     (o_valid),
        .o_out_pos_x (o_out_pos_x),
        .o_out_pos_y (o_out_pos_y),
        .o_out_vel_x (o_out_vel_x),
        .o_out_vel_y (o_out_vel_y),
        .o_arrived   (o_arrived)
    );

endmodule

[tb/sv/elastic_position_follower_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// elastic_position_follower_tb
// self-checking bench for the 2d spring-damper position follower: a directed
// table (reset behaviour, arrival, extremes, retargeting) and then random
// target/tick sequences under several gain settings, with bursty input
// beats and a stalling receiver, checked beat by beat against a
// cycle-free model of the follower
// ----------------------------------------------------------------------------
module elastic_position_follower_tb;

    localparam int     W             = epf_pkg::COORD_WIDTH;
    localparam longint C_MAX         = (longint'(1) <<< (W - 1)) - 1;
    localparam longint C_MIN         = -C_MAX - 1;
    localparam int     CYCLE_LIMIT   = 600000;
    localparam int     SETTLE_CYCLES = 16;
    localparam int     PHASE_ITEMS   = 110;
    localparam bit     MODE_TARGET   = 1'b0;
    localparam bit     MODE_TICK     = 1'b1;

    typedef logic signed [W-1:0] t_coord;

    typedef struct {
        t_coord pos_x;
        t_coord pos_y;
        t_coord vel_x;
        t_coord vel_y;
        logic   arrived;
    } t_beat;

    typedef struct {
        bit     mode;
        t_coord gx;
        t_coord gy;
        bit     typed;
        bit     has_beat;
        t_beat  want;
    } t_row;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_MOSTLY,
        RX_CHOKE
    } t_rx_style;

    localparam t_coord G_MAX = {1'b0, {(W-1){1'b1}}};
    localparam t_coord G_MIN = {1'b1, {(W-1){1'b0}}};

    // dut ports
    logic                           i_clk      = 1'b0;
    logic                           i_rst_n    = 1'b0;
    logic                           i_valid    = 1'b0;
    logic                           o_ready;
    logic                           i_mode     = MODE_TICK;
    t_coord                         i_goal_x   = '0;
    t_coord                         i_goal_y   = '0;
    logic                           o_valid;
    logic                           i_ready    = 1'b0;
    t_coord                         o_out_pos_x;
    t_coord                         o_out_pos_y;
    t_coord                         o_out_vel_x;
    t_coord                         o_out_vel_y;
    logic                           o_arrived;
    logic                           i_cfg_we   = 1'b0;
    logic [epf_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [epf_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    // follower model state, as after reset
    longint tgt_x = 0, tgt_y = 0;
    longint pos_x = 0, pos_y = 0;
    longint vel_x = 0, vel_y = 0;
    bit     armed = 1'b0;
    longint gain_smooth = epf_pkg::SMOOTH_RESET;
    longint gain_resp   = epf_pkg::RESP_RESET;

    t_beat     pending_beats [$];
    int        mismatches  = 0;
    int        cycle_count = 0;
    int        burst_left  = 0;
    int        rx_left     = 0;
    t_rx_style rx_style    = RX_OPEN;

    // directed table: expected beat typed in where it is obvious
    t_row plan [0:22] = '{
        // tick straight after reset: disarmed, dropped
        '{MODE_TICK,   0,     0,     1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TARGET, 0,     0,     1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        // already on target: snaps at once
        '{MODE_TICK,   0,     0,     1'b1, 1'b1, '{0, 0, 0, 0, 1'b1}},
        // disarmed again after arrival
        '{MODE_TICK,   0,     0,     1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        // target inside the stop circle, negative axis
        '{MODE_TARGET, 10,    -10,   1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b1, 1'b1, '{10, -10, 0, 0, 1'b1}},
        // far corner
        '{MODE_TARGET, G_MAX, G_MAX, 1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   G_MAX, G_MIN, 1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        // retarget while armed: motion carries on
        '{MODE_TARGET, G_MIN, G_MIN, 1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TARGET, G_MAX, G_MIN, 1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        // alternating bit patterns on the goal fields
        '{MODE_TARGET, 24'sh555555, 24'shAAAAAA, 1'b1, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}},
        '{MODE_TICK,   0,     0,     1'b0, 1'b0, '{0, 0, 0, 0, 1'b0}}
    };

    elastic_position_follower u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_mode      (i_mode),
        .i_goal_x    (i_goal_x),
        .i_goal_y    (i_goal_y),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_pos_x (o_out_pos_x),
        .o_out_pos_y (o_out_pos_y),
        .o_out_vel_x (o_out_vel_x),
        .o_out_vel_y (o_out_vel_y),
        .o_arrived   (o_arrived),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    // ---------------- follower model ----------------

    function automatic longint clamp_coord(longint v);
        return (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
    endfunction

    // floor(a * g / 2^16)
    function automatic longint scale_q16(longint a, longint g);
        return (a * g) >>> 16;
    endfunction

    // both components within 0.1 of zero, compared squared
    function automatic bit settled(longint a, longint b);
        if (a >= epf_pkg::STOP_LSB || a <= -epf_pkg::STOP_LSB
            || b >= epf_pkg::STOP_LSB || b <= -epf_pkg::STOP_LSB) begin
            return 1'b0;
        end
        return (a * a + b * b) <= epf_pkg::STOP_SQ;
    endfunction

    function automatic longint blend_velocity(longint tgt, longint pos, longint vel);
        longint ideal;
        ideal = scale_q16(tgt - pos, gain_resp);
        return clamp_coord(vel + scale_q16(ideal - vel, 65536 - gain_smooth));
    endfunction

    // one accepted beat; returns 1 when it yields a result beat
    function automatic bit advance_follower(input bit mode, input t_coord gx,
                                            input t_coord gy, output t_beat beat);
        bit hit;
        beat = '{default: 0};
        if (mode == MODE_TARGET) begin
            tgt_x = gx;
            tgt_y = gy;
            armed = 1'b1;
            return 1'b0;
        end
        if (!armed) begin
            return 1'b0;
        end
        vel_x = blend_velocity(tgt_x, pos_x, vel_x);
        vel_y = blend_velocity(tgt_y, pos_y, vel_y);
        pos_x = clamp_coord(pos_x + vel_x);
        pos_y = clamp_coord(pos_y + vel_y);
        hit = settled(vel_x, vel_y) && settled(tgt_x - pos_x, tgt_y - pos_y);
        if (hit) begin
            pos_x = tgt_x;
            pos_y = tgt_y;
            vel_x = 0;
            vel_y = 0;
            armed = 1'b0;
        end
        beat.pos_x   = t_coord'(pos_x);
        beat.pos_y   = t_coord'(pos_y);
        beat.vel_x   = t_coord'(vel_x);
        beat.vel_y   = t_coord'(vel_y);
        beat.arrived = hit;
        return 1'b1;
    endfunction

    // register write as the block clamps it
    function automatic void apply_gain(epf_pkg::t_cfg_idx idx,
                                       logic [epf_pkg::CFG_DATA_W-1:0] d);
        longint v;
        case (idx)
            epf_pkg::CFG_SMOOTH: begin
                v = longint'(d[epf_pkg::SMOOTH_W-1:0]);
                if (v < epf_pkg::SMOOTH_MIN) v = epf_pkg::SMOOTH_MIN;
                if (v > epf_pkg::SMOOTH_MAX) v = epf_pkg::SMOOTH_MAX;
                gain_smooth = v;
            end
            epf_pkg::CFG_RESP: begin
                v = longint'(d[epf_pkg::RESP_W-1:0]);
                if (v < epf_pkg::RESP_MIN) v = epf_pkg::RESP_MIN;
                if (v > epf_pkg::RESP_MAX) v = epf_pkg::RESP_MAX;
                gain_resp = v;
            end
            default: ;
        endcase
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic t_coord random_coord();
        return t_coord'($urandom);
    endfunction

    // base plus a signed offset of up to 2^k, clamped
    function automatic t_coord near_coord(longint base, int k);
        longint span;
        span = longint'(1) << k;
        return t_coord'(clamp_coord(base + longint'($urandom_range(0, int'(2 * span))) - span));
    endfunction

    function automatic t_coord far_coord();
        case ($urandom_range(0, 4))
            0:       return G_MAX;
            1:       return G_MIN;
            2:       return '0;
            3:       return near_coord(C_MAX, 10);
            default: return random_coord();
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d, expected %0d (cycle %0d)",
                 what, got, want, cycle_count);
        mismatches++;
    endtask

    // drive one input beat in bursts, record its expected result on acceptance
    task automatic send_item(input bit mode, input t_coord gx, input t_coord gy,
                             input bit typed, input bit typed_has, input t_beat typed_want,
                             output bit produced);
        int    gap;
        bit    has;
        t_beat beat;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid  <= 1'b1;
        i_mode   <= mode;
        i_goal_x <= gx;
        i_goal_y <= gy;
        do @(posedge i_clk); while (!o_ready);
        burst_left--;
        has = advance_follower(mode, gx, gy, beat);
        if (typed) begin
            has  = typed_has;
            beat = typed_want;
        end
        if (has) begin
            pending_beats.push_back(beat);
        end
        produced = has;
    endtask

    // stop sending and wait for every outstanding result beat
    task automatic drain_results(input int extra);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (extra) @(negedge i_clk);
    endtask

    // write both gains while the block is idle
    task automatic configure_gains(input logic [epf_pkg::CFG_DATA_W-1:0] smooth_raw,
                                   input logic [epf_pkg::CFG_DATA_W-1:0] resp_raw);
        epf_pkg::t_cfg_idx              sel;
        logic [epf_pkg::CFG_DATA_W-1:0] data;
        drain_results(SETTLE_CYCLES);
        for (int k = 0; k < 2; k++) begin
            if (k == 0) begin
                sel  = epf_pkg::CFG_SMOOTH;
                data = smooth_raw;
            end else begin
                sel  = epf_pkg::CFG_RESP;
                data = resp_raw;
            end
            @(negedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= sel;
            i_cfg_data <= data;
            @(posedge i_clk);
            apply_gain(sel, data);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // ticks with junk goal fields; mostly stop soon after arrival
    task automatic run_ticks(input int n, inout int counted);
        bit    produced;
        t_beat none;
        none = '{default: 0};
        for (int i = 0; i < n; i++) begin
            send_item(MODE_TICK, random_coord(), random_coord(), 1'b0, 1'b0, none, produced);
            if (produced) counted++;
            if (!armed && $urandom_range(0, 3) != 0) break;
        end
    endtask

    task automatic send_target(input t_coord gx, input t_coord gy, inout int counted);
        bit    produced;
        t_beat none;
        none = '{default: 0};
        send_item(MODE_TARGET, gx, gy, 1'b0, 1'b0, none, produced);
        counted++;
    endtask

    // random phase: mostly target-then-ticks runs, some retargets and noise
    task automatic run_random(input int items);
        int counted;
        int pick;
        int k;
        counted = 0;
        while (counted < items) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                k = $urandom_range(2, 14);
                send_target(near_coord(pos_x, k), near_coord(pos_y, k), counted);
                run_ticks($urandom_range(1, 60), counted);
            end else if (pick < 74) begin
                send_target(far_coord(), far_coord(), counted);
                run_ticks($urandom_range(5, 40), counted);
            end else if (pick < 85) begin
                k = $urandom_range(4, 10);
                send_target(near_coord(pos_x, k), near_coord(pos_y, k), counted);
                run_ticks($urandom_range(1, 8), counted);
                send_target(near_coord(pos_x, k), near_coord(pos_y, k), counted);
                run_ticks($urandom_range(1, 30), counted);
            end else if (pick < 97) begin
                run_ticks($urandom_range(1, 4), counted);
                if ($urandom_range(0, 1) == 0) begin
                    send_target(random_coord(), random_coord(), counted);
                end
            end else begin
                drain_results(0);
            end
        end
    endtask

    // ---------------- receiver ----------------

    // stall pattern that redraws its style each time the rx_left counter runs out
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_style = t_rx_style'($urandom_range(0, 3));
            rx_left  = $urandom_range(16, 96);
        end else begin
            rx_left--;
        end
        case (rx_style)
            RX_OPEN:   i_ready <= 1'b1;
            RX_COIN:   i_ready <= 1'($urandom_range(0, 1));
            RX_MOSTLY: i_ready <= ($urandom_range(0, 7) != 0);
            default:   i_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // result beat check against the oldest expectation
    always @(posedge i_clk) begin
        t_beat got;
        t_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_out_pos_x, o_out_pos_y, o_out_vel_x, o_out_vel_y, o_arrived};
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected result beat, pos_x", got.pos_x, 0);
            end else begin
                want = pending_beats.pop_front();
                if (got.pos_x !== want.pos_x) report_mismatch("pos_x", got.pos_x, want.pos_x);
                if (got.pos_y !== want.pos_y) report_mismatch("pos_y", got.pos_y, want.pos_y);
                if (got.vel_x !== want.vel_x) report_mismatch("vel_x", got.vel_x, want.vel_x);
                if (got.vel_y !== want.vel_y) report_mismatch("vel_y", got.vel_y, want.vel_y);
                if (got.arrived !== want.arrived) begin
                    report_mismatch("arrived", got.arrived, want.arrived);
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        bit                             produced;
        logic [epf_pkg::CFG_DATA_W-1:0] s_raw;
        logic [epf_pkg::CFG_DATA_W-1:0] r_raw;

        // synchronous reset, held from the start of the run
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at reset gains
        foreach (plan[i]) begin
            send_item(plan[i].mode, plan[i].gx, plan[i].gy, plan[i].typed,
                      plan[i].has_beat, plan[i].want, produced);
        end

        // random phases over a spread of gain settings
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    s_raw = 16'h0000;
                    r_raw = 16'hFFFF;
                end
                1: begin
                    s_raw = 16'hFFFF;
                    r_raw = 16'h0000;
                end
                2: begin
                    s_raw = 16'(6554);
                    r_raw = 16'(13107);
                end
                3: begin
                    // upper bits above the 14-bit gain are dropped
                    s_raw = 16'(58982);
                    r_raw = 16'h42BC;
                end
                4: begin
                    s_raw = 16'($urandom);
                    r_raw = 16'($urandom);
                end
                default: begin
                    s_raw = 16'($urandom_range(epf_pkg::SMOOTH_MIN, epf_pkg::SMOOTH_MAX));
                    r_raw = 16'($urandom_range(epf_pkg::RESP_MIN, epf_pkg::RESP_MAX));
                end
            endcase
            configure_gains(s_raw, r_raw);
            run_random(PHASE_ITEMS);
        end

        drain_results(2 * SETTLE_CYCLES);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
